// ===== design/geofence_fix_watchdog_assert.svh =====
// Assertion helpers for the checker file of this block.
`ifndef GEOFENCE_FIX_WATCHDOG_ASSERT_SVH
`define GEOFENCE_FIX_WATCHDOG_ASSERT_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define GFW_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset names.
`define GFW_ASSERT(lbl, prop, msg) `GFW_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// ===== design/gfw_pkg.sv =====
package gfw_pkg;

   // Number of fenced axes, in the order x, y, z.
   localparam int GFW_AXES     = 3;
   localparam int GFW_MAX_AXES = 3;

   localparam int GFW_CSR_INDEX_W = 3;
   localparam int GFW_CSR_DATA_W  = 32;
   localparam int GFW_COORD_W     = 32;
   localparam int GFW_COUNT_W     = 12;

   // Register indexes.
   localparam logic [GFW_CSR_INDEX_W-1:0] CSR_UPPER_X           = 3'd0;
   localparam logic [GFW_CSR_INDEX_W-1:0] CSR_LOWER_X           = 3'd1;
   localparam logic [GFW_CSR_INDEX_W-1:0] CSR_UPPER_Y           = 3'd2;
   localparam logic [GFW_CSR_INDEX_W-1:0] CSR_LOWER_Y           = 3'd3;
   localparam logic [GFW_CSR_INDEX_W-1:0] CSR_UPPER_Z           = 3'd4;
   localparam logic [GFW_CSR_INDEX_W-1:0] CSR_LOWER_Z           = 3'd5;
   localparam logic [GFW_CSR_INDEX_W-1:0] CSR_ACCURACY_THRESHOLD = 3'd6;

   // Fence bounds after reset, element 0 is the x axis.
   localparam logic [GFW_MAX_AXES-1:0][GFW_COORD_W-1:0] GFW_UPPER_RST = {
      32'sd100000000, 32'sd900000000, 32'sd1800000000
   };
   localparam logic [GFW_MAX_AXES-1:0][GFW_COORD_W-1:0] GFW_LOWER_RST = {
      -32'sd100000000, -32'sd900000000, -32'sd1800000000
   };

   // Report levels and timing constants.
   localparam logic [2:0] GFW_LEVEL_NONE = 3'd0;
   localparam logic [2:0] GFW_LEVEL_OUT  = 3'd4;
   localparam logic [2:0] GFW_LEVEL_IN   = 3'd5;
   localparam logic [5:0] GFW_MIN_SATS   = 6'd4;

   localparam logic [GFW_COUNT_W-1:0] GFW_SAT_TIMEOUT = 12'h800;
   localparam logic [GFW_COUNT_W-1:0] GFW_FIX_TIMEOUT = 12'h100;
   localparam logic [GFW_COUNT_W-1:0] GFW_COUNT_MAX   = 12'hFFF;

   localparam logic [9:0] GFW_LONG_SLEEP  = 10'd900;
   localparam logic [9:0] GFW_SHORT_SLEEP = 10'd120;
   localparam logic [9:0] GFW_NO_SLEEP    = 10'd0;

   typedef struct packed {
      logic                          fix_is_3d;
      logic [7:0]                    accuracy_level;
      logic [5:0]                    num_sats;
      logic                          usb_active;
      logic signed [GFW_COORD_W-1:0] pos_x;
      logic signed [GFW_COORD_W-1:0] pos_y;
      logic signed [GFW_COORD_W-1:0] pos_z;
   } gfw_req_type;

   typedef struct packed {
      logic       sleep_request;
      logic [9:0] sleep_seconds;
      logic [2:0] report_level;
      logic [2:0] worst_level_now;
   } gfw_rsp_type;

endpackage

// ===== design/geofence_fix_watchdog.sv =====
// A report transfer is taken into the input register, then moves on to the
// result register, from which its result transfer is offered.
// Throughput: one report per clock while the result is not stalled; the
// worst-level and counter update is combinational, so back-to-back reports
// never wait on each other.
// Reset is synchronous and active high: it restores the fence bounds and the
// threshold to their defaults and clears the worst level, counter and valids.
module geofence_fix_watchdog #(
   parameter int AXES = gfw_pkg::GFW_AXES
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  gfw_pkg::gfw_req_type               req,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output gfw_pkg::gfw_rsp_type               rsp,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gfw_pkg::GFW_CSR_INDEX_W-1:0] csr_index,
   input  logic [gfw_pkg::GFW_CSR_DATA_W-1:0]  csr_data
);
   import gfw_pkg::*;

   // Configuration registers. Only the axes that are fenced keep bounds.
   logic [AXES-1:0][GFW_COORD_W-1:0] upper_ff;
   logic [AXES-1:0][GFW_COORD_W-1:0] lower_ff;
   logic [7:0]                       threshold_ff;
   logic                             csr_fire;

   // Input stage and result stage.
   logic        s1_valid_ff, s1_valid_in;
   gfw_req_type s1_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   gfw_rsp_type rsp_ff, rsp_in;

   // Watchdog state.
   logic [2:0]             worst_ff, worst_in;
   logic [GFW_COUNT_W-1:0] count_ff, count_in;

   logic                   req_fire;
   logic                   out_free;
   logic                   s1_move;
   logic [2:0]             level;
   logic [2:0]             worst_max;
   logic [GFW_COUNT_W-1:0] count_inc;
   logic                   timeout_reset;

   // The register port never pushes back; writes land in the next cycle.
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   // Bound registers are written at index 2*axis (upper) and 2*axis+1
   // (lower). Writes to axes that are not fenced are dropped.
   for (genvar a = 0; a < AXES; a++) begin : g_bounds
      always_ff @(posedge clock) begin
         if (reset) begin
            upper_ff[a] <= GFW_UPPER_RST[a];
            lower_ff[a] <= GFW_LOWER_RST[a];
         end else if (csr_fire) begin
            if (csr_index == CSR_UPPER_X + GFW_CSR_INDEX_W'(2 * a)) begin
               upper_ff[a] <= csr_data[GFW_COORD_W-1:0];
            end
            if (csr_index == CSR_LOWER_X + GFW_CSR_INDEX_W'(2 * a)) begin
               lower_ff[a] <= csr_data[GFW_COORD_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 8'd0;
      end else if (csr_fire && csr_index == CSR_ACCURACY_THRESHOLD) begin
         threshold_ff <= csr_data[7:0];
      end
   end

   // Handshake. The input register refills in the same cycle it drains, so
   // it only holds off a new transfer while the result register is stuck.
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign s1_move   = s1_valid_ff & out_free;
   assign req_stall = s1_valid_ff & ~out_free;
   assign req_fire  = req_valid & ~req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   gfw_level #(
      .AXES (AXES)
   ) u_level (
      .report             (s1_ff),
      .upper              (upper_ff),
      .lower              (lower_ff),
      .accuracy_threshold (threshold_ff),
      .level              (level)
   );

   // Watchdog update for the report leaving the input register. An active
   // host link clears the counter and suppresses any request, but the worst
   // level still tracks the report. Otherwise the counter saturates upward
   // and a timeout returns the state to its reset values.
   always_comb begin
      worst_max     = (level > worst_ff) ? level : worst_ff;
      count_inc     = (count_ff < GFW_COUNT_MAX) ? count_ff + GFW_COUNT_W'(1) : count_ff;
      timeout_reset = 1'b0;
      rsp_in.sleep_request = 1'b0;
      rsp_in.sleep_seconds = GFW_NO_SLEEP;
      rsp_in.report_level  = level;
      worst_in      = worst_max;
      count_in      = count_inc;

      if (s1_ff.usb_active) begin
         count_in = '0;
      end else begin
         if (worst_max < GFW_LEVEL_OUT) begin
            if (count_inc >= GFW_SAT_TIMEOUT) begin
               rsp_in.sleep_request = 1'b1;
               rsp_in.sleep_seconds = GFW_LONG_SLEEP;
               timeout_reset        = 1'b1;
            end
         end else if (worst_max == GFW_LEVEL_OUT) begin
            if (count_inc >= GFW_FIX_TIMEOUT) begin
               rsp_in.sleep_request = 1'b1;
               rsp_in.sleep_seconds = GFW_SHORT_SLEEP;
               timeout_reset        = 1'b1;
            end
         end else if (count_inc >= GFW_FIX_TIMEOUT) begin
            // Inside the fence long enough: restart quietly.
            timeout_reset = 1'b1;
         end
         if (timeout_reset) begin
            worst_in = GFW_LEVEL_NONE;
            count_in = '0;
         end
      end
      rsp_in.worst_level_now = worst_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         worst_ff     <= GFW_LEVEL_NONE;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            worst_ff <= worst_in;
            count_ff <= count_in;
         end
      end
   end

   // Payload registers carry no reset; their valids qualify them.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= req;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== design/gfw_level.sv =====
module gfw_level #(
   parameter int AXES = gfw_pkg::GFW_AXES
) (
   input  gfw_pkg::gfw_req_type                  report,
   input  logic [AXES-1:0][gfw_pkg::GFW_COORD_W-1:0] upper,
   input  logic [AXES-1:0][gfw_pkg::GFW_COORD_W-1:0] lower,
   input  logic [7:0]                            accuracy_threshold,
   output logic [2:0]                            level
);
   import gfw_pkg::*;

   logic [GFW_MAX_AXES-1:0][GFW_COORD_W-1:0] pos;
   logic [AXES-1:0]                          outside;

   assign pos = {report.pos_z, report.pos_y, report.pos_x};

   // A normal range rejects values above or below it; a wrapped range only
   // rejects values that sit in the gap between upper and lower.
   for (genvar a = 0; a < AXES; a++) begin : g_axis
      logic above;
      logic below;
      assign above = $signed(pos[a]) > $signed(upper[a]);
      assign below = $signed(pos[a]) < $signed(lower[a]);
      assign outside[a] = ($signed(upper[a]) >= $signed(lower[a])) ? (above | below)
                                                                     : (above & below);
   end

   always_comb begin
      level = GFW_LEVEL_OUT;
      if (report.fix_is_3d) begin
         if (report.accuracy_level >= accuracy_threshold) begin
            level = (|outside) ? GFW_LEVEL_OUT : GFW_LEVEL_IN;
         end
      end else if (report.num_sats < GFW_MIN_SATS) begin
         level = {1'b0, report.num_sats[1:0]};
      end
   end

endmodule

// ===== design/gfw_checker.sv =====
module gfw_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input gfw_pkg::gfw_rsp_type                rsp
);
   import gfw_pkg::*;
`include "geofence_fix_watchdog_assert.svh"

   // A result held back by the consumer stays put.
   `GFW_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "result changed while stalled")

   // A sleep request always names one of the two times and clears the worst level.
   `GFW_ASSERT(a_req_fields, rsp_valid && rsp.sleep_request |-> (rsp.sleep_seconds == GFW_LONG_SLEEP || rsp.sleep_seconds == GFW_SHORT_SLEEP) && rsp.worst_level_now == GFW_LEVEL_NONE, "bad sleep request fields")

   // Without a request there is no sleep time.
   `GFW_ASSERT(a_no_req_secs, rsp_valid && !rsp.sleep_request |-> rsp.sleep_seconds == GFW_NO_SLEEP, "sleep time without request")

   // The long sleep only follows reports below the out-of-range level, the
   // short one never follows an in-fence report.
   `GFW_ASSERT(a_req_level, rsp_valid && rsp.sleep_request |-> (rsp.sleep_seconds == GFW_LONG_SLEEP && rsp.report_level < GFW_LEVEL_OUT) || (rsp.sleep_seconds == GFW_SHORT_SLEEP && rsp.report_level <= GFW_LEVEL_OUT), "sleep request inconsistent with level")

   // The input is only held off while a result sits in the result register.
   `GFW_ASSERT(a_in_free, !rsp_valid |-> !req_stall, "input stalled with result register empty")

endmodule

bind geofence_fix_watchdog gfw_checker u_gfw_checker (.*);
